>>> src/delta_list_task_scheduler_unit_assert.svh
// Assertion macros for the delta-list task scheduler checker.
// Included by the checker file; no other dependencies.
`ifndef DELTA_LIST_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define DELTA_LIST_TASK_SCHEDULER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define DLT_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define DLT_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> src/dlts_pkg.sv
// Package for the delta-list task scheduler: sizes, codes and payload types.
// No dependencies.
package dlts_pkg;
    localparam int MAX_TASKS   = 16;
    localparam int READY_DEPTH = 16;
    localparam int LW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int RW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int LCW = $clog2(MAX_TASKS + 1);
    localparam int RCW = $clog2(READY_DEPTH + 1);

    typedef enum logic [1:0] {
        K_TICK = 2'd0, K_ADD = 2'd1, K_DISPATCH = 2'd2, K_DELETE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] delay_ticks;
        logic [31:0] period_ticks;
        logic [7:0]  task_handle;
        logic [7:0]  task_argument;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        run_valid;
        logic [15:0] run_id;
        logic [7:0]  run_handle;
        logic [7:0]  run_argument;
        logic        task_retired;
        logic        moved_to_ready;
    } t_rsp;
endpackage

>>> src/dlts_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on dlts_pkg.
interface dlts_req_if;
    logic           valid;
    logic           ready;
    dlts_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dlts_rsp_if;
    logic           valid;
    logic           ready;
    dlts_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/delta_list_task_scheduler_unit.sv
// Top level of the delta-list task scheduler: list, ready FIFO and sequencer.
// Depends on dlts_pkg and dlts_if.sv. An empty-list tick, a refused request or
// a retiring dispatch responds directly from IDLE; a decrementing tick passes
// DEC, OUT; a head-moving tick DEC, POP, OUT; delete POP, OUT; add or a periodic
// dispatch WALK, SHIFT, PLACE, OUT. A new request is taken only once the last
// response is taken. Reset clears state, counts, ready head, id and valid only.
module delta_list_task_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlts_req_if.sink    i_req,
    dlts_rsp_if.source  o_rsp
);
    import dlts_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_PLACE = 7'b0010000,
        S_POP   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    // stores
    logic [31:0] r_ldelta [MAX_TASKS];
    logic [31:0] r_lper   [MAX_TASKS];
    logic [31:0] r_ltag   [MAX_TASKS];
    logic [31:0] r_rper   [READY_DEPTH];
    logic [31:0] r_rtag   [READY_DEPTH];

    t_state       r_state, n_state;
    logic [LCW-1:0] r_lcnt;
    logic [RCW-1:0] r_rcnt;
    logic [RW-1:0]  r_rhead;
    logic [15:0]    r_nid;
    logic [LCW-1:0] r_i;       // walk / shift index
    logic [32:0]    r_acc;
    logic [31:0]    r_delay, r_per, r_tag, r_hd;
    logic           r_pop_del; // pop for delete adds head delta forward
    t_rsp           r_rsp;
    logic           r_ovalid;

    // walk adder: accumulates the cumulative delta along the list
    logic [LW-1:0]  w_ix;
    logic [32:0]    w_sum;
    logic [RW-1:0]  w_slot;
    logic           w_retire;
    assign w_ix   = r_i[LW-1:0];
    assign w_sum  = r_acc + {1'b0, r_ldelta[w_ix]};
    assign w_slot = RW'((32'(r_rhead) + 32'(r_rcnt)) % READY_DEPTH);
    // dispatched task is dropped when one-shot or when the list has no room
    assign w_retire = (r_rper[r_rhead] == '0) || (r_lcnt >= LCW'(MAX_TASKS));

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lcnt   <= '0;
            r_rcnt   <= '0;
            r_rhead  <= '0;
            r_nid    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_acc <= '0;
                        unique case (t_kind'(i_req.data.kind))
                            K_TICK: begin
                                r_rsp <= '0;
                                if (r_lcnt == '0) begin
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_state <= S_DEC;
                                end
                            end
                            K_ADD: begin
                                r_i     <= '0;
                                r_delay <= i_req.data.delay_ticks;
                                r_per   <= i_req.data.period_ticks;
                                r_tag   <= {i_req.data.task_argument,
                                            i_req.data.task_handle, r_nid};
                                if (r_lcnt >= LCW'(MAX_TASKS)) begin
                                    r_rsp <= '{status: 1'b1, default: '0};
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_rsp <= '{run_id: r_nid, default: '0};
                                    r_nid   <= r_nid + 16'd1;
                                    r_state <= S_WALK;
                                end
                            end
                            K_DISPATCH: begin
                                r_i <= '0;
                                if (r_rcnt == '0) begin
                                    r_rsp <= '{status: 1'b1, default: '0};
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_rsp <= '{run_valid:    1'b1,
                                               run_id:       r_rtag[r_rhead][15:0],
                                               run_handle:   r_rtag[r_rhead][23:16],
                                               run_argument: r_rtag[r_rhead][31:24],
                                               task_retired: w_retire,
                                               default:      '0};
                                    r_delay <= r_rper[r_rhead];
                                    r_per   <= r_rper[r_rhead];
                                    r_tag   <= r_rtag[r_rhead];
                                    r_rhead <= RW'((32'(r_rhead) + 1) % READY_DEPTH);
                                    r_rcnt  <= r_rcnt - RCW'(1);
                                    if (w_retire) begin
                                        r_ovalid <= 1'b1;
                                    end else begin
                                        r_state <= S_WALK;
                                    end
                                end
                            end
                            default: begin
                                if (r_lcnt == '0) begin
                                    r_rsp <= '{status: 1'b1, default: '0};
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_rsp     <= '0;
                                    r_hd      <= r_ldelta[0];
                                    r_pop_del <= 1'b1;
                                    r_i       <= LCW'(1);
                                    r_state   <= S_POP;
                                end
                            end
                        endcase
                    end
                end
                // tick on a non-empty list
                S_DEC: begin
                    if (r_ldelta[0] != '0) begin
                        r_ldelta[0] <= r_ldelta[0] - 32'd1;
                        r_state <= S_OUT;
                    end else if (r_rcnt >= RCW'(READY_DEPTH)) begin
                        r_rsp.status <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_rper[w_slot] <= r_lper[0];
                        r_rtag[w_slot] <= r_ltag[0];
                        r_rcnt <= r_rcnt + RCW'(1);
                        r_rsp.moved_to_ready <= 1'b1;
                        r_pop_del <= 1'b0;
                        r_i <= LCW'(1);
                        r_state <= S_POP;
                    end
                end
                // one cumulative-delta step per cycle
                S_WALK: begin
                    if (r_i == r_lcnt) begin
                        r_state <= S_SHIFT;
                        r_i <= r_lcnt;
                        r_hd <= r_delay - r_acc[31:0];
                        r_acc <= 33'(r_lcnt);  // insert at the tail
                    end else if ({1'b0, r_delay} < w_sum) begin
                        r_hd <= r_delay - r_acc[31:0];
                        r_ldelta[w_ix] <= 32'(w_sum - {1'b0, r_delay});
                        r_acc <= 33'(r_i);  // reuse acc as insert point
                        r_i <= r_lcnt;
                        r_state <= S_SHIFT;
                    end else begin
                        r_acc <= w_sum;
                        r_i <= r_i + LCW'(1);
                    end
                end
                // shift entries up one per cycle down to the insert point
                S_SHIFT: begin
                    if (r_i == LCW'(r_acc)) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_ldelta[w_ix] <= r_ldelta[LW'(r_i - LCW'(1))];
                        r_lper[w_ix]   <= r_lper[LW'(r_i - LCW'(1))];
                        r_ltag[w_ix]   <= r_ltag[LW'(r_i - LCW'(1))];
                        r_i <= r_i - LCW'(1);
                    end
                end
                S_PLACE: begin
                    r_ldelta[w_ix] <= r_hd;
                    r_lper[w_ix]   <= r_per;
                    r_ltag[w_ix]   <= r_tag;
                    r_lcnt <= r_lcnt + LCW'(1);
                    r_state <= S_OUT;
                end
                // remove the head, one entry moved down per cycle
                S_POP: begin
                    if (r_i >= r_lcnt) begin
                        r_lcnt <= r_lcnt - LCW'(1);
                        if (r_pop_del && r_lcnt > LCW'(1)) begin
                            r_ldelta[0] <= r_ldelta[0] + r_hd;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_ldelta[LW'(r_i - LCW'(1))] <= r_ldelta[w_ix];
                        r_lper[LW'(r_i - LCW'(1))]   <= r_lper[w_ix];
                        r_ltag[LW'(r_i - LCW'(1))]   <= r_ltag[w_ix];
                        r_i <= r_i + LCW'(1);
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/dlts_checker.sv
// Port-level checker for the scheduler top level, attached by bind.
// Depends on dlts_pkg and delta_list_task_scheduler_unit_assert.svh.
`include "delta_list_task_scheduler_unit_assert.svh"
module dlts_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input dlts_pkg::t_rsp i_rsp_data
);
    import dlts_pkg::*;
    // no new request while a response waits
    `DLT_ASSERT_IMP(a_busy, i_clk, i_rst_n, i_rsp_valid, !i_req_ready)
    // stalled response holds
    `DLT_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_rsp_data))
    // a delivered task is never also refused
    `DLT_ASSERT_IMP(a_excl, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.run_valid,
        !i_rsp_data.status && !i_rsp_data.moved_to_ready)
    // request accepted means not ready next cycle
    `DLT_ASSERT_NXT(a_seq, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
endmodule

bind delta_list_task_scheduler_unit dlts_checker u_dlts_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready), .i_rsp_data(o_rsp.data)
);
